### sv/msp_pkg.sv
`default_nettype none

package msp_pkg;

    // Port widths fixed by the interface
    localparam int VALUE_PORT_W = 16;
    localparam int INDEX_PORT_W = 3;
    localparam int MARK_W       = 2;
    localparam int DIM_CFG_W    = 4;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 4'd5;

    // Cell mark codes
    localparam logic [MARK_W-1:0] MARK_NONE   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_ROW    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_COL    = 2'd2;
    localparam logic [MARK_W-1:0] MARK_SADDLE = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_en;        // write an accepted cell
        logic first_col_cell; // loaded cell sits in column zero
        logic first_row_cell; // loaded cell sits in row zero
        logic reduce_init;    // seed maximin and minimax
        logic reduce_en;      // fold one row/column into maximin and minimax
        logic row_ok;         // reduce index is a row in use
        logic col_ok;         // reduce index is a column in use
        logic rd_en;          // read the cell store
        logic out_load;       // move the read stage into the output register
        logic s1_last;        // read stage holds the final cell
    } msp_cmd_t;

endpackage

`default_nettype wire

### sv/msp_ctrl.sv
`default_nettype none

module msp_ctrl
    import msp_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr,
    input  wire logic [DIM_CFG_W-1:0]              row_count_cfg,
    input  wire logic [DIM_CFG_W-1:0]              column_count_cfg,
    input  wire logic                              cell_valid,
    output logic                                   cell_stall,
    input  wire logic                              result_stall,
    output logic                                   result_valid,
    output msp_cmd_t                               cmd,
    output logic [$clog2(MAX_DIM)-1:0]             row_sel,
    output logic [$clog2(MAX_DIM)-1:0]             col_sel,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     mem_addr,
    output logic [$clog2(MAX_DIM)-1:0]             s1_row,
    output logic [$clog2(MAX_DIM)-1:0]             s1_col
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_REDUCE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  lr_reg, lc_reg;
    logic [ADDR_W-1:0] laddr_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  er_reg, ec_reg;
    logic [ADDR_W-1:0] eaddr_reg;
    logic              emit_more_reg;
    logic              s1_valid_reg;
    logic [IDX_W-1:0]  s1_row_reg, s1_col_reg;
    logic              s1_last_reg;
    logic              out_valid_reg;

    logic [IDX_W-1:0]  rows_last, cols_last, red_last;
    logic              cell_accept, load_last, reduce_done;
    logic              advance, issue, emit_last;

    // Clamp the dimensions to 2..MAX_DIM and keep the last index
    function automatic logic [IDX_W-1:0] last_index(input logic [DIM_CFG_W-1:0] d);
        logic [DIM_CFG_W-1:0] t;
        if (d < DIM_CFG_W'(2))
            t = DIM_CFG_W'(2);
        else if (d > DIM_CFG_W'(MAX_DIM))
            t = DIM_CFG_W'(MAX_DIM);
        else
            t = d;
        return IDX_W'(t - DIM_CFG_W'(1));
    endfunction

    assign rows_last = last_index(row_count_cfg);
    assign cols_last = last_index(column_count_cfg);
    assign red_last  = (rows_last > cols_last) ? rows_last : cols_last;

    assign cell_accept = (state_reg == ST_LOAD) && cell_valid;
    assign load_last   = (lr_reg == rows_last) && (lc_reg == cols_last);
    assign reduce_done = (state_reg == ST_REDUCE) && (idx_reg == red_last);
    assign advance     = !out_valid_reg || !result_stall;
    assign issue       = (state_reg == ST_EMIT) && emit_more_reg && advance;
    assign emit_last   = (er_reg == rows_last) && (ec_reg == cols_last);

    assign cell_stall   = (state_reg != ST_LOAD);
    assign result_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (cell_accept && load_last)
                    state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (reduce_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!emit_more_reg && advance)
                    state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Select the row/column entry and store address for the datapath
    always_comb
    begin
        unique case (state_reg)
            ST_REDUCE:
            begin
                row_sel = idx_reg;
                col_sel = idx_reg;
            end
            ST_EMIT:
            begin
                row_sel = s1_row_reg;
                col_sel = s1_col_reg;
            end
            default:
            begin
                row_sel = lr_reg;
                col_sel = lc_reg;
            end
        endcase
    end

    assign mem_addr = (state_reg == ST_EMIT) ? eaddr_reg : laddr_reg;
    assign s1_row   = s1_row_reg;
    assign s1_col   = s1_col_reg;

    always_comb
    begin
        cmd                = '0;
        cmd.load_en        = cell_accept;
        cmd.first_col_cell = (lc_reg == '0);
        cmd.first_row_cell = (lr_reg == '0);
        cmd.reduce_init    = cell_accept && load_last;
        cmd.reduce_en      = (state_reg == ST_REDUCE);
        cmd.row_ok         = (idx_reg <= rows_last);
        cmd.col_ok         = (idx_reg <= cols_last);
        cmd.rd_en          = issue;
        cmd.out_load       = advance && s1_valid_reg;
        cmd.s1_last        = s1_last_reg;
    end

    // State, counters and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            lr_reg        <= '0;
            lc_reg        <= '0;
            laddr_reg     <= '0;
            idx_reg       <= '0;
            er_reg        <= '0;
            ec_reg        <= '0;
            eaddr_reg     <= '0;
            emit_more_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Advance the load position; a register write restarts the matrix
            if (cfg_wr)
            begin
                lr_reg    <= '0;
                lc_reg    <= '0;
                laddr_reg <= '0;
            end
            else if (cell_accept)
            begin
                if (load_last)
                begin
                    lr_reg    <= '0;
                    lc_reg    <= '0;
                    laddr_reg <= '0;
                end
                else
                begin
                    laddr_reg <= laddr_reg + ADDR_W'(1);
                    if (lc_reg == cols_last)
                    begin
                        lc_reg <= '0;
                        lr_reg <= lr_reg + IDX_W'(1);
                    end
                    else
                    begin
                        lc_reg <= lc_reg + IDX_W'(1);
                    end
                end
            end

            // Step through rows and columns for the reduction
            if (cell_accept && load_last)
                idx_reg <= '0;
            else if (state_reg == ST_REDUCE)
                idx_reg <= idx_reg + IDX_W'(1);

            // Walk the emit position
            if (reduce_done)
            begin
                er_reg        <= '0;
                ec_reg        <= '0;
                eaddr_reg     <= '0;
                emit_more_reg <= 1'b1;
            end
            else if (issue)
            begin
                eaddr_reg <= eaddr_reg + ADDR_W'(1);
                if (emit_last)
                    emit_more_reg <= 1'b0;
                if (ec_reg == cols_last)
                begin
                    ec_reg <= '0;
                    er_reg <= er_reg + IDX_W'(1);
                end
                else
                begin
                    ec_reg <= ec_reg + IDX_W'(1);
                end
            end

            if (advance)
            begin
                s1_valid_reg  <= issue;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Read stage position, no reset needed
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_row_reg  <= er_reg;
            s1_col_reg  <= ec_reg;
            s1_last_reg <= emit_last;
        end
    end

endmodule

`default_nettype wire

### sv/msp_dpath.sv
`default_nettype none

module msp_dpath
    import msp_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire msp_cmd_t                            cmd,
    input  wire logic [$clog2(MAX_DIM)-1:0]          row_sel,
    input  wire logic [$clog2(MAX_DIM)-1:0]          col_sel,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  mem_addr,
    input  wire logic [$clog2(MAX_DIM)-1:0]          s1_row,
    input  wire logic [$clog2(MAX_DIM)-1:0]          s1_col,
    input  wire logic signed [VALUE_PORT_W-1:0]      cell_value,
    output logic [INDEX_PORT_W-1:0]                  row_index,
    output logic [INDEX_PORT_W-1:0]                  column_index,
    output logic [MARK_W-1:0]                        cell_mark,
    output logic signed [VALUE_PORT_W-1:0]           reported_value,
    output logic signed [VALUE_PORT_W-1:0]           maximin_value,
    output logic signed [VALUE_PORT_W-1:0]           minimax_value,
    output logic                                     last_result
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;

    localparam logic signed [VALUE_BITS-1:0] LARGEST  = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] SMALLEST = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic signed [VALUE_BITS-1:0] cell_v;
    logic signed [VALUE_BITS-1:0] mem [DEPTH];
    logic signed [VALUE_BITS-1:0] rd_data_reg;
    logic signed [VALUE_BITS-1:0] row_min_reg [MAX_DIM];
    logic signed [VALUE_BITS-1:0] col_max_reg [MAX_DIM];
    logic signed [VALUE_BITS-1:0] row_min_next, col_max_next;
    logic signed [VALUE_BITS-1:0] row_cur, col_cur;
    logic signed [VALUE_BITS-1:0] maximin_reg, minimax_reg;
    logic                         row_hit, col_hit;
    logic [MARK_W-1:0]            mark;

    logic [IDX_W-1:0]             out_row_reg, out_col_reg;
    logic [MARK_W-1:0]            out_mark_reg;
    logic signed [VALUE_BITS-1:0] out_value_reg, out_maximin_reg, out_minimax_reg;
    logic                         out_last_reg;

    // Take the low VALUE_BITS bits of the input, or zero-extend it when VALUE_BITS is wider
    generate
        if (VALUE_BITS < VALUE_PORT_W)
        begin : g_in_narrow
            assign cell_v = cell_value[VALUE_BITS-1:0];
        end
        else if (VALUE_BITS == VALUE_PORT_W)
        begin : g_in_equal
            assign cell_v = cell_value;
        end
        else
        begin : g_in_wide
            assign cell_v = {{(VALUE_BITS-VALUE_PORT_W){1'b0}}, cell_value};
        end
    endgenerate

    // Cell store
    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
            mem[mem_addr] <= cell_v;
        if (cmd.rd_en)
            rd_data_reg <= mem[mem_addr];
    end

    assign row_cur = row_min_reg[row_sel];
    assign col_cur = col_max_reg[col_sel];

    // Row minimum and column maximum; the first cell of a row or column seeds it
    assign row_min_next = (cmd.first_col_cell || (cell_v < row_cur)) ? cell_v : row_cur;
    assign col_max_next = (cmd.first_row_cell || (cell_v > col_cur)) ? cell_v : col_cur;

    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
        begin
            row_min_reg[row_sel] <= row_min_next;
            col_max_reg[col_sel] <= col_max_next;
        end
    end

    // Fold one row and one column per cycle into maximin and minimax
    always_ff @(posedge clk)
    begin
        if (cmd.reduce_init)
        begin
            maximin_reg <= SMALLEST;
            minimax_reg <= LARGEST;
        end
        else if (cmd.reduce_en)
        begin
            if (cmd.row_ok && (row_cur > maximin_reg))
                maximin_reg <= row_cur;
            if (cmd.col_ok && (col_cur < minimax_reg))
                minimax_reg <= col_cur;
        end
    end

    // Mark the cell in the read stage
    assign row_hit = (rd_data_reg == row_cur) && (row_cur == maximin_reg);
    assign col_hit = (rd_data_reg == col_cur) && (col_cur == minimax_reg);
    assign mark    = (row_hit ? MARK_ROW : MARK_NONE) | (col_hit ? MARK_COL : MARK_NONE);

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_row_reg     <= s1_row;
            out_col_reg     <= s1_col;
            out_mark_reg    <= mark;
            out_value_reg   <= rd_data_reg;
            out_maximin_reg <= maximin_reg;
            out_minimax_reg <= minimax_reg;
            out_last_reg    <= cmd.s1_last;
        end
    end

    assign row_index    = INDEX_PORT_W'(out_row_reg);
    assign column_index = INDEX_PORT_W'(out_col_reg);
    assign cell_mark    = out_mark_reg;
    assign last_result  = out_last_reg;

    // Fit values to the port width
    generate
        if (VALUE_BITS < VALUE_PORT_W)
        begin : g_out_narrow
            localparam int EXT = VALUE_PORT_W - VALUE_BITS;
            assign reported_value = {{EXT{out_value_reg[VALUE_BITS-1]}}, out_value_reg};
            assign maximin_value  = {{EXT{out_maximin_reg[VALUE_BITS-1]}}, out_maximin_reg};
            assign minimax_value  = {{EXT{out_minimax_reg[VALUE_BITS-1]}}, out_minimax_reg};
        end
        else if (VALUE_BITS == VALUE_PORT_W)
        begin : g_out_equal
            assign reported_value = out_value_reg;
            assign maximin_value  = out_maximin_reg;
            assign minimax_value  = out_minimax_reg;
        end
        else
        begin : g_out_wide
            assign reported_value = out_value_reg[VALUE_PORT_W-1:0];
            assign maximin_value  = out_maximin_reg[VALUE_PORT_W-1:0];
            assign minimax_value  = out_minimax_reg[VALUE_PORT_W-1:0];
        end
    endgenerate

endmodule

`default_nettype wire

### sv/matrix_saddle_point_marker.sv
// Matrix saddle-point marker. Cells of a signed matrix of row_count x column_count
// entries (each clamped to 2..MAX_DIM) enter in row-major order on the cell channel,
// one per cycle while cell_stall is low; the final cell of the matrix starts a
// reduction over the rows and columns, one row minimum and one column maximum per
// cycle, after which one result per cell leaves in row-major order at one per cycle
// while result_stall is low, behind a registered read of the cell store. That store
// has one port, shared by loading and by the emit pass, so cell_stall stays high
// through the reduction and the emit pass. The next matrix may load while the final
// result still waits to be taken. Any register write restarts loading and drops a
// partial matrix; write the registers only while the block is idle.
`default_nettype none

module matrix_saddle_point_marker
    import msp_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [APB_ADDR_W-1:0]          paddr,
    input  wire logic [APB_DATA_W-1:0]          pwdata,
    output logic [APB_DATA_W-1:0]               prdata,
    output logic                                pready,
    input  wire logic                           cell_valid,
    output logic                                cell_stall,
    input  wire logic signed [VALUE_PORT_W-1:0] cell_value,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic [INDEX_PORT_W-1:0]             row_index,
    output logic [INDEX_PORT_W-1:0]             column_index,
    output logic [MARK_W-1:0]                   cell_mark,
    output logic signed [VALUE_PORT_W-1:0]      reported_value,
    output logic signed [VALUE_PORT_W-1:0]      maximin_value,
    output logic signed [VALUE_PORT_W-1:0]      minimax_value,
    output logic                                last_result
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

    logic [DIM_CFG_W-1:0] row_count_reg, column_count_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    msp_cmd_t          cmd;
    logic [IDX_W-1:0]  row_sel, col_sel, s1_row, s1_col;
    logic [ADDR_W-1:0] mem_addr;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= DIM_RESET;
            column_count_reg <= DIM_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ROW_COUNT:    row_count_reg    <= pwdata[DIM_CFG_W-1:0];
                REG_COLUMN_COUNT: column_count_reg <= pwdata[DIM_CFG_W-1:0];
                default:          row_count_reg    <= row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ROW_COUNT:    prdata = APB_DATA_W'(row_count_reg);
            REG_COLUMN_COUNT: prdata = APB_DATA_W'(column_count_reg);
            default:          prdata = '0;
        endcase
    end

    msp_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr           (cfg_wr),
        .row_count_cfg    (row_count_reg),
        .column_count_cfg (column_count_reg),
        .cell_valid       (cell_valid),
        .cell_stall       (cell_stall),
        .result_stall     (result_stall),
        .result_valid     (result_valid),
        .cmd              (cmd),
        .row_sel          (row_sel),
        .col_sel          (col_sel),
        .mem_addr         (mem_addr),
        .s1_row           (s1_row),
        .s1_col           (s1_col)
    );

    msp_dpath #(
        .MAX_DIM    (MAX_DIM),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk            (clk),
        .cmd            (cmd),
        .row_sel        (row_sel),
        .col_sel        (col_sel),
        .mem_addr       (mem_addr),
        .s1_row         (s1_row),
        .s1_col         (s1_col),
        .cell_value     (cell_value),
        .row_index      (row_index),
        .column_index   (column_index),
        .cell_mark      (cell_mark),
        .reported_value (reported_value),
        .maximin_value  (maximin_value),
        .minimax_value  (minimax_value),
        .last_result    (last_result)
    );

    // A cell transfer never shares the store port with an emit read
    a_port_shared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_en |-> !cmd.rd_en)
        else $error("cell store written and read in the same cycle");

    // Nothing follows the final result of a matrix right away
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && last_result) |=> !result_valid)
        else $error("result follows the final cell of a matrix");

    // A saddle point equals both maximin and minimax
    a_saddle_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (cell_mark == MARK_SADDLE)) |->
            ((reported_value == maximin_value) && (reported_value == minimax_value)))
        else $error("saddle point value differs from maximin or minimax");

endmodule

`default_nettype wire

### tb/tb_matrix_saddle_point_marker.sv
`default_nettype none

module tb_matrix_saddle_point_marker;
    import msp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM_LIMIT    = 8;
    localparam int CELL_TARGET  = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PAUSE   = 20;
    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT  = 2000;

    localparam logic signed [VALUE_PORT_W-1:0] VALUE_MAX = 16'sh7fff;
    localparam logic signed [VALUE_PORT_W-1:0] VALUE_MIN = 16'sh8000;

    // Value styles for generated matrices
    localparam int STYLE_WIDE    = 0;
    localparam int STYLE_NARROW  = 1;
    localparam int STYLE_EXTREME = 2;

    typedef struct packed {
        logic [INDEX_PORT_W-1:0] row;
        logic [INDEX_PORT_W-1:0] column;
        logic [MARK_W-1:0]       mark;
        logic [VALUE_PORT_W-1:0] value;
        logic [VALUE_PORT_W-1:0] maximin;
        logic [VALUE_PORT_W-1:0] minimax;
        logic                    last;
    } cell_report_t;

    // Saddle-point predictor and queue of expected cell reports
    class saddle_scoreboard;
        logic [DIM_CFG_W-1:0]           rows_reg;
        logic [DIM_CFG_W-1:0]           cols_reg;
        logic signed [VALUE_PORT_W-1:0] cells [DIM_LIMIT*DIM_LIMIT];
        logic signed [VALUE_PORT_W-1:0] row_min [DIM_LIMIT];
        logic signed [VALUE_PORT_W-1:0] col_max [DIM_LIMIT];
        int                             loaded;
        cell_report_t                   pending_marks [$];
        int                             errors;

        function new();
            rows_reg = DIM_RESET;
            cols_reg = DIM_RESET;
            loaded   = 0;
            errors   = 0;
        endfunction

        function int clamp_dim(logic [DIM_CFG_W-1:0] d);
            if (d < 2)
                return 2;
            if (d > DIM_LIMIT)
                return DIM_LIMIT;
            return int'(d);
        endfunction

        function int total_cells();
            return clamp_dim(rows_reg) * clamp_dim(cols_reg);
        endfunction

        // Any register write drops the partial matrix
        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DIM_CFG_W-1:0] value);
            if (idx == REG_ROW_COUNT)
                rows_reg = value;
            else if (idx == REG_COLUMN_COUNT)
                cols_reg = value;
            loaded = 0;
        endfunction

        function void load_cell(logic signed [VALUE_PORT_W-1:0] v);
            int rows;
            int cols;
            int total;
            int i;
            int r;
            int c;
            logic signed [VALUE_PORT_W-1:0] maximin;
            logic signed [VALUE_PORT_W-1:0] minimax;
            logic signed [VALUE_PORT_W-1:0] x;
            cell_report_t want;
            rows  = clamp_dim(rows_reg);
            cols  = clamp_dim(cols_reg);
            total = rows * cols;
            if (loaded >= total)
                loaded = 0;
            if (loaded == 0) begin
                for (i = 0; i < DIM_LIMIT; i++) begin
                    row_min[i] = VALUE_MAX;
                    col_max[i] = VALUE_MIN;
                end
            end
            r = loaded / cols;
            c = loaded % cols;
            cells[loaded] = v;
            if (v < row_min[r])
                row_min[r] = v;
            if (v > col_max[c])
                col_max[c] = v;
            loaded++;
            if (loaded < total)
                return;

            // Reduce rows and columns, then mark every cell in row-major order
            maximin = VALUE_MIN;
            for (i = 0; i < rows; i++)
                if (row_min[i] > maximin)
                    maximin = row_min[i];
            minimax = VALUE_MAX;
            for (i = 0; i < cols; i++)
                if (col_max[i] < minimax)
                    minimax = col_max[i];
            for (r = 0; r < rows; r++) begin
                for (c = 0; c < cols; c++) begin
                    x = cells[r*cols + c];
                    want.mark = MARK_NONE;
                    if (x == row_min[r] && row_min[r] == maximin)
                        want.mark = want.mark | MARK_ROW;
                    if (x == col_max[c] && col_max[c] == minimax)
                        want.mark = want.mark | MARK_COL;
                    want.row     = INDEX_PORT_W'(r);
                    want.column  = INDEX_PORT_W'(c);
                    want.value   = x;
                    want.maximin = maximin;
                    want.minimax = minimax;
                    want.last    = (r*cols + c + 1 == total);
                    pending_marks.push_back(want);
                end
            end
            loaded = 0;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task compare_field(string name, logic [VALUE_PORT_W-1:0] got,
                           logic [VALUE_PORT_W-1:0] want, cell_report_t ref_cell);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h expected %0h at cell (%0d,%0d)",
                                          name, got, want, ref_cell.row, ref_cell.column));
        endtask

        task check_report(cell_report_t got);
            cell_report_t want;
            if (pending_marks.size() == 0) begin
                report_mismatch($sformatf("unexpected result for cell (%0d,%0d)",
                                          got.row, got.column));
                return;
            end
            want = pending_marks.pop_front();
            compare_field("row_index", 16'(got.row), 16'(want.row), want);
            compare_field("column_index", 16'(got.column), 16'(want.column), want);
            compare_field("cell_mark", 16'(got.mark), 16'(want.mark), want);
            compare_field("reported_value", got.value, want.value, want);
            compare_field("maximin_value", got.maximin, want.maximin, want);
            compare_field("minimax_value", got.minimax, want.minimax, want);
            compare_field("last_result", 16'(got.last), 16'(want.last), want);
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [APB_ADDR_W-1:0]          paddr;
    logic [APB_DATA_W-1:0]          pwdata;
    logic [APB_DATA_W-1:0]          prdata;
    logic                           pready;
    logic                           cell_valid;
    logic                           cell_stall;
    logic signed [VALUE_PORT_W-1:0] cell_value;
    logic                           result_valid;
    logic                           result_stall;
    logic [INDEX_PORT_W-1:0]        row_index;
    logic [INDEX_PORT_W-1:0]        column_index;
    logic [MARK_W-1:0]              cell_mark;
    logic signed [VALUE_PORT_W-1:0] reported_value;
    logic signed [VALUE_PORT_W-1:0] maximin_value;
    logic signed [VALUE_PORT_W-1:0] minimax_value;
    logic                           last_result;

    saddle_scoreboard sb = new();
    bit               hold_armed = 1'b0;
    int               cells_sent = 0;
    int               quiet_cycles = 0;

    matrix_saddle_point_marker DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .cell_valid     (cell_valid),
        .cell_stall     (cell_stall),
        .cell_value     (cell_value),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .row_index      (row_index),
        .column_index   (column_index),
        .cell_mark      (cell_mark),
        .reported_value (reported_value),
        .maximin_value  (maximin_value),
        .minimax_value  (minimax_value),
        .last_result    (last_result)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Note each transfer on either channel at the rising edge
    always @(posedge clk) begin
        if (rst_n && cell_valid && !cell_stall)
            sb.load_cell(cell_value);
        if (rst_n && result_valid && !result_stall)
            sb.check_report({row_index, column_index, cell_mark, reported_value,
                             maximin_value, minimax_value, last_result});
    end

    // Abort when neither channel moves for too long
    always @(posedge clk) begin
        if ((cell_valid && !cell_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, long free runs, and one long hold-off on request
    initial begin
        int pick;
        int span;
        result_stall = 1'b0;
        forever begin
            if (hold_armed) begin
                result_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_armed = 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    result_stall = 1'b0;
                    span = $urandom_range(1, 20);
                end else if (pick < 60) begin
                    result_stall = 1'b0;
                    span = $urandom_range(30, 80);
                end else if (pick < 95) begin
                    result_stall = 1'b1;
                    span = $urandom_range(1, 3);
                end else begin
                    result_stall = 1'b1;
                    span = $urandom_range(10, 40);
                end
                // Cut the span short as soon as a hold-off is requested
                while (span > 0 && !hold_armed) begin
                    @(negedge clk);
                    span--;
                end
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [VALUE_PORT_W-1:0] pick_value(int style);
        case (style)
            STYLE_WIDE:   return VALUE_PORT_W'($urandom);
            STYLE_NARROW: return VALUE_PORT_W'($urandom_range(0, 6)) - 16'd3;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return VALUE_MIN;
                    1:       return VALUE_MAX;
                    2:       return 16'h0000;
                    3:       return 16'hffff;
                    default: return VALUE_PORT_W'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic logic [DIM_CFG_W-1:0] pick_dim();
        if ($urandom_range(0, 99) < 80)
            return DIM_CFG_W'($urandom_range(2, 4));
        return DIM_CFG_W'($urandom_range(0, 15));
    endfunction

    // Offer one cell after an optional gap; return at the falling edge after the transfer
    task automatic send_cell(input logic [VALUE_PORT_W-1:0] v, input int gap);
        if (gap > 0) begin
            cell_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cell_valid = 1'b1;
        cell_value = v;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
        cells_sent++;
        @(negedge clk);
    endtask

    task automatic send_matrix(input int count, input int style, input bit burst);
        int i;
        for (i = 0; i < count; i++)
            send_cell(pick_value(style), burst ? 0 : pick_gap());
    endtask

    // Drop valid, drain all expected reports, then let the block settle
    task automatic wait_idle();
        cell_valid = 1'b0;
        while (sb.pending_marks.size() != 0)
            @(negedge clk);
        repeat (IDLE_PAUSE) @(negedge clk);
    endtask

    // Register write: setup phase, then access phase until pready
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [DIM_CFG_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = APB_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin
        int phase;
        int count;
        int style;
        int total;
        int i;
        logic [DIM_CFG_W-1:0] rows_cfg;
        logic [DIM_CFG_W-1:0] cols_cfg;
        bit burst;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cell_valid = 1'b0;
        cell_value = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Dimensions below range act as 2: extreme values, no saddle point
        write_reg(REG_ROW_COUNT, 4'd0);
        write_reg(REG_COLUMN_COUNT, 4'd1);
        send_cell(VALUE_MIN, 0);
        send_cell(VALUE_MAX, 0);
        send_cell(16'h0000, 1);
        send_cell(16'hffff, 0);
        // Single saddle point in the corner
        send_cell(16'd3, 0);
        send_cell(16'd5, 2);
        send_cell(16'd1, 0);
        send_cell(16'd7, 0);
        wait_idle();

        // Partial matrix dropped by a register write
        send_matrix(3, STYLE_WIDE, 1'b0);
        wait_idle();
        write_reg(REG_ROW_COUNT, 4'd2);
        write_reg(REG_COLUMN_COUNT, 4'd3);
        // All cells tie: every cell is a saddle point
        for (i = 0; i < 6; i++)
            send_cell(16'h0123, 0);
        wait_idle();

        // Random phases: extreme shapes first, then mostly small matrices
        phase = 0;
        while (cells_sent < CELL_TARGET) begin
            case (phase)
                0:       begin rows_cfg = 4'd15; cols_cfg = 4'd9;  end
                1:       begin rows_cfg = 4'd2;  cols_cfg = 4'd8;  end
                2:       begin rows_cfg = 4'd3;  cols_cfg = 4'd3;  end
                3:       begin rows_cfg = 4'd9;  cols_cfg = 4'd2;  end
                4:       begin rows_cfg = 4'd1;  cols_cfg = 4'd15; end
                5:       begin rows_cfg = 4'd5;  cols_cfg = 4'd5;  end
                default: begin rows_cfg = pick_dim(); cols_cfg = pick_dim(); end
            endcase
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_ROW_COUNT, rows_cfg);
                write_reg(REG_COLUMN_COUNT, cols_cfg);
            end else begin
                write_reg(REG_COLUMN_COUNT, cols_cfg);
                write_reg(REG_ROW_COUNT, rows_cfg);
            end
            total = sb.total_cells();

            // Hold the receiver off while back-to-back matrices fill the block
            if (phase == 2) begin
                hold_armed = 1'b1;
                for (i = 0; i < 4; i++)
                    send_matrix(total, STYLE_NARROW, 1'b1);
            end else begin
                count = (total > 16) ? 1 : $urandom_range(1, 3);
                for (i = 0; i < count; i++) begin
                    style = $urandom_range(STYLE_WIDE, STYLE_EXTREME);
                    burst = ($urandom_range(0, 3) == 0);
                    send_matrix(total, style, burst);
                end
            end

            // Sometimes leave a broken matrix for the next write to drop
            if ($urandom_range(0, 99) < 30)
                send_matrix($urandom_range(1, total - 1), STYLE_WIDE, 1'b0);
            wait_idle();
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending_marks.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
